/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects signals named
// clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSP_CHECK(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("format spec parser check failed");

// Consequent must hold in the cycle after the antecedent.
`define FSP_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("format spec parser check failed");

`endif

/* src/fsp_pkg.sv */
package fsp_pkg;

    // Accumulator widths.
    localparam int NUM_BITS = 16;
    localparam int LEN_BITS = 8;

    localparam logic [NUM_BITS-1:0] NUM_MAX = '1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Characters of interest.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_PCT   = 8'h25;

    typedef enum logic [3:0] {
        TC_CHAR    = 4'd0,
        TC_STRING  = 4'd1,
        TC_POINTER = 4'd2,
        TC_DEC     = 4'd3,
        TC_INT     = 4'd4,
        TC_UNS     = 4'd5,
        TC_HEX_LC  = 4'd6,
        TC_HEX_UC  = 4'd7,
        TC_PERCENT = 4'd8,
        TC_OTHER   = 4'd9
    } type_code_t;

    typedef enum logic [3:0] {
        PH_FLAGS = 4'b0001,
        PH_WIDTH = 4'b0010,
        PH_PREC  = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic minus;
        logic plus;
        logic space;
        logic hash;
    } flag_bits_t;

    // Classification of one character.
    typedef struct packed {
        logic       is_minus;
        logic       is_plus;
        logic       is_space;
        logic       is_hash;
        logic       is_zero;
        logic       is_digit;
        logic       is_dot;
        logic [3:0] digit;
        type_code_t code;
    } char_class_t;

    typedef struct packed {
        phase_t              phase;
        flag_bits_t          flags;
        logic [LEN_BITS-1:0] zero_tally;
        logic [NUM_BITS-1:0] width_acc;
        logic                dot_seen;
        logic [NUM_BITS-1:0] prec_acc;
        logic [LEN_BITS-1:0] char_count;
        logic                sat_seen;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:      PH_FLAGS,
        flags:      '0,
        zero_tally: '0,
        width_acc:  '0,
        dot_seen:   1'b0,
        prec_acc:   '0,
        char_count: '0,
        sat_seen:   1'b0
    };

    typedef struct packed {
        flag_bits_t          flags;
        logic [LEN_BITS-1:0] zero_count;
        logic [NUM_BITS-1:0] field_width;
        logic                has_dot;
        logic [NUM_BITS-1:0] precision_value;
        type_code_t          code;
        logic [LEN_BITS-1:0] spec_length;
        logic                saturated;
    } spec_result_t;

    // Saturating increment; the top bit of the result is the clamp flag.
    function automatic logic [LEN_BITS:0] sat_inc(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS:0] r;
        if (v == LEN_MAX) begin
            r = {1'b1, LEN_MAX};
        end else begin
            r = {1'b0, v + LEN_BITS'(1)};
        end
        return r;
    endfunction

    // v * 10 + d with clamp; the top bit of the result is the clamp flag.
    function automatic logic [NUM_BITS:0] add_digit(input logic [NUM_BITS-1:0] v,
                                                   input logic [3:0] d);
        logic [NUM_BITS+3:0] n;
        logic [NUM_BITS:0]   r;
        n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{NUM_BITS{1'b0}}, d};
        if (n > {4'b0, NUM_MAX}) begin
            r = {1'b1, NUM_MAX};
        end else begin
            r = {1'b0, n[NUM_BITS-1:0]};
        end
        return r;
    endfunction

endpackage

/* src/fsp_class.sv */
module fsp_class import fsp_pkg::*; (
    input  logic [7:0]  ch,
    output char_class_t cls
);

    logic [7:0] offset;
    type_code_t code;

    assign offset       = ch - CH_ZERO;
    assign cls.is_minus = (ch == CH_MINUS);
    assign cls.is_plus  = (ch == CH_PLUS);
    assign cls.is_space = (ch == CH_SPACE);
    assign cls.is_hash  = (ch == CH_HASH);
    assign cls.is_zero  = (ch == CH_ZERO);
    assign cls.is_dot   = (ch == CH_DOT);
    assign cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign cls.digit    = offset[3:0];
    assign cls.code     = code;

    always_comb
    begin
        unique case (ch)
            CH_LC_C: code = TC_CHAR;
            CH_LC_S: code = TC_STRING;
            CH_LC_P: code = TC_POINTER;
            CH_LC_D: code = TC_DEC;
            CH_LC_I: code = TC_INT;
            CH_LC_U: code = TC_UNS;
            CH_LC_X: code = TC_HEX_LC;
            CH_UC_X: code = TC_HEX_UC;
            CH_PCT:  code = TC_PERCENT;
            default: code = TC_OTHER;
        endcase
    end

endmodule

/* src/fsp_core.sv */
module fsp_core import fsp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  char_class_t  cls,
    input  logic         first,
    input  logic         step,
    output logic         emit,
    output spec_result_t res
);

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t cur;
    logic [LEN_BITS:0] cnt_inc;
    logic [LEN_BITS:0] zero_inc;
    logic [NUM_BITS:0] width_add;
    logic [NUM_BITS:0] prec_add;
    logic              consume;

    // A first mark restarts the specification before the character is used.
    assign cur       = first ? STATE_CLEAR : st_reg;
    assign cnt_inc   = sat_inc(cur.char_count);
    assign zero_inc  = sat_inc(cur.zero_tally);
    assign width_add = add_digit(cur.phase == PH_FLAGS ? '0 : cur.width_acc, cls.digit);
    assign prec_add  = add_digit(cur.prec_acc, cls.digit);

    always_comb
    begin
        st_next = cur;
        emit    = 1'b0;
        consume = 1'b0;
        unique case (cur.phase)
            PH_FLAGS:
            begin
                priority if (cls.is_minus) begin
                    st_next.flags.minus = 1'b1;
                    consume = 1'b1;
                end else if (cls.is_plus) begin
                    st_next.flags.plus = 1'b1;
                    consume = 1'b1;
                end else if (cls.is_space) begin
                    st_next.flags.space = 1'b1;
                    consume = 1'b1;
                end else if (cls.is_hash) begin
                    st_next.flags.hash = 1'b1;
                    consume = 1'b1;
                end else if (cls.is_zero) begin
                    st_next.zero_tally = zero_inc[LEN_BITS-1:0];
                    st_next.sat_seen   = cur.sat_seen | zero_inc[LEN_BITS];
                    consume = 1'b1;
                end else if (cls.is_digit) begin
                    st_next.width_acc = width_add[NUM_BITS-1:0];
                    st_next.sat_seen  = cur.sat_seen | width_add[NUM_BITS];
                    st_next.phase     = PH_WIDTH;
                    consume = 1'b1;
                end else if (cls.is_dot) begin
                    st_next.dot_seen = 1'b1;
                    st_next.phase    = PH_PREC;
                    consume = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_WIDTH:
            begin
                priority if (cls.is_digit) begin
                    st_next.width_acc = width_add[NUM_BITS-1:0];
                    st_next.sat_seen  = cur.sat_seen | width_add[NUM_BITS];
                    consume = 1'b1;
                end else if (cls.is_dot) begin
                    st_next.dot_seen = 1'b1;
                    st_next.phase    = PH_PREC;
                    consume = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_PREC:
            begin
                if (cls.is_digit) begin
                    st_next.prec_acc = prec_add[NUM_BITS-1:0];
                    st_next.sat_seen = cur.sat_seen | prec_add[NUM_BITS];
                    consume = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_DONE:
            begin
                st_next = cur;
            end
            default:
            begin
                st_next = cur;
            end
        endcase

        if (consume) begin
            st_next.char_count = cnt_inc[LEN_BITS-1:0];
            st_next.sat_seen   = st_next.sat_seen | cnt_inc[LEN_BITS];
        end
        if (emit) begin
            st_next.phase = PH_DONE;
        end
    end

    // The result reports the fields as they stood before the type character.
    assign res.flags           = cur.flags;
    assign res.zero_count      = cur.zero_tally;
    assign res.field_width     = cur.width_acc;
    assign res.has_dot         = cur.dot_seen;
    assign res.precision_value = cur.prec_acc;
    assign res.code            = cls.code;
    assign res.spec_length     = cur.char_count;
    assign res.saturated       = cur.sat_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= STATE_CLEAR;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

endmodule

/* src/format_spec_parser_top.sv */
// A word enters the input register, then updates the parse state; one that
// ends a specification fills the result register and sets out_valid.
// Throughput: one word per cycle unless an emitting word finds the result
// register full and untaken; the parse-state update is all the per-word work.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the flags phase with all accumulators cleared.
`include "assert_macros.svh"

module format_spec_parser_top import fsp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        first,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        left_align,
    output logic        force_sign,
    output logic        space_sign,
    output logic [1:0]  alt_form,
    output logic [7:0]  zero_count,
    output logic [15:0] field_width,
    output logic        has_dot,
    output logic [15:0] precision_value,
    output logic [3:0]  type_code,
    output logic [7:0]  spec_length,
    output logic        saturated
);

    // Input register: holds one word waiting to update the parse state.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_ch_reg;
    logic        s1_first_reg;

    // Result register: holds one finished specification until it is taken.
    logic         out_valid_reg;
    logic         out_valid_next;
    spec_result_t res_reg;

    char_class_t  cls;
    spec_result_t core_res;
    logic         core_emit;
    logic         s1_step;
    logic         in_fire;

    // The held word moves on unless it would emit a result while the result
    // register is still full and not being taken this cycle. Words that
    // produce no result never wait on the output side.
    assign s1_step  = s1_valid_reg && !(core_emit && out_valid_reg && !out_ready);
    assign in_ready = !s1_valid_reg || s1_step;
    assign in_fire  = in_valid && in_ready;

    fsp_class u_class (
        .ch  (s1_ch_reg),
        .cls (cls)
    );

    fsp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cls   (cls),
        .first (s1_first_reg),
        .step  (s1_step),
        .emit  (core_emit),
        .res   (core_res)
    );

    always_comb
    begin
        priority if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_step) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        priority if (s1_step && core_emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_ch_reg    <= ch;
            s1_first_reg <= first;
        end
        if (s1_step && core_emit) begin
            res_reg <= core_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign left_align      = res_reg.flags.minus;
    assign force_sign      = res_reg.flags.plus;
    assign space_sign      = res_reg.flags.space;
    assign alt_form        = res_reg.flags.hash ? 2'd2 : 2'd0;
    assign zero_count      = res_reg.zero_count;
    assign field_width     = res_reg.field_width;
    assign has_dot         = res_reg.has_dot;
    assign precision_value = res_reg.precision_value;
    assign type_code       = res_reg.code;
    assign spec_length     = res_reg.spec_length;
    assign saturated       = res_reg.saturated;

    // A new word may only enter when the held word leaves in the same cycle.
    `FSP_CHECK(a_no_input_overrun, in_fire && s1_valid_reg, s1_step)
    // A full result register that is not taken is never overwritten.
    `FSP_CHECK(a_no_result_overwrite, out_valid_reg && !out_ready, !(s1_step && core_emit))
    // An emitting step always leaves a valid result behind.
    `FSP_CHECK_NEXT(a_emit_shows_result, s1_step && core_emit, out_valid_reg)
    // Results never carry a type code beyond the defined range.
    `FSP_CHECK(a_code_range, out_valid_reg, res_reg.code <= TC_OTHER)

endmodule
